// ===== rtl/spa_pkg.sv =====
// Package for the slot pool allocator: item structs, command and status codes,
// and the command/status structs between the controller and the datapath.
// No dependencies; every other file in rtl/ uses it by scoped names.
package spa_pkg;

  // Default number of slots in the pool.
  localparam int DEF_POOL_SLOTS = 8;

  // Command codes of a request item.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UNLOAD = 1'b1;

  // Status codes of a response item.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  // Request item.
  typedef struct packed {
    logic        command;
    logic [15:0] owner_id;
  } req_t;

  // Response item.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot_index;
    logic [3:0]  occupancy;
    logic [3:0]  peak_occupancy;
    logic [31:0] load_count;
    logic [31:0] unload_count;
    logic [31:0] blocked_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;    // latch the accepted request and rewind the scan
    logic scan;     // step the scan by one slot
    logic capture;  // record the scan outcome
    logic commit;   // update the table and counters, load the response
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // the slot under compare satisfies the request
    logic miss_last; // the last slot was compared without a hit
    logic out_free;  // the response register can take a new item
  } dp_stat_t;

endpackage

// ===== rtl/slot_pool_allocator.sv =====
// Slot pool allocator: a table of POOL_SLOTS slots with identifier and in-use
// mark. A load takes the lowest free slot, an unload frees the lowest slot
// whose identifier matches.
//
// Request channel (req_valid, req_stall, req): an item is taken at a clock
// edge with req_valid high and req_stall low. req_stall is high while an item
// is in work. Response channel (rsp_valid, rsp_stall, rsp): one response per
// request, held in an output register until taken.
//
// Scan: the scan reads one slot per cycle through the identifier memory,
// whose read is registered ahead of the compare. The scan stops at the
// first hit; a full-table load or an unload with no match ends at the last
// slot. The response is loaded at commit, and req_stall falls at the same
// edge, so the next item is taken only after the response is loaded. If
// the previous response is still stalled, the commit waits.
//
// Reset frees every slot and clears occupancy, peak and the counters; no
// clearing pass is needed. The identifier store is not reset.
module slot_pool_allocator #(
  parameter int POOL_SLOTS = spa_pkg::DEF_POOL_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spa_pkg::rsp_t rsp
);

  spa_pkg::dp_cmd_t  cmd;
  spa_pkg::dp_stat_t stat;

  // Sequencer.
  spa_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Table, counters and response register.
  spa_datapath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/spa_datapath.sv =====
// Datapath of the slot pool allocator: identifier memory, in-use bits, scan
// pipeline, occupancy and event counters, and the response register.
// Depends on spa_pkg; driven by spa_controller through spa_pkg::dp_cmd_t.
module spa_datapath #(
  parameter int POOL_SLOTS = spa_pkg::DEF_POOL_SLOTS
) (
  input  logic             clk,
  input  logic             rst,
  input  spa_pkg::req_t    req,
  input  spa_pkg::dp_cmd_t cmd,
  output spa_pkg::dp_stat_t stat,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output spa_pkg::rsp_t    rsp
);

  localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CW = $clog2(POOL_SLOTS + 1);
  localparam int OW = (CW > 4) ? CW : 4;
  localparam int XW = (IW > 3) ? IW : 3;
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SLOTS - 1);

  // Identifier store; entries are only compared while their slot is in use.
  logic [15:0]     ids_mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] slot_used;

  // Latched request.
  logic            cmd_q;
  logic [15:0]     id_q;

  // Scan pipeline: read address, then compare stage.
  logic [IW-1:0]   idx;
  logic            cmp_vld;
  logic [IW-1:0]   cmp_idx;
  logic [15:0]     rd_data;

  // Scan outcome.
  logic            found_q;
  logic [IW-1:0]   where_q;

  // Occupancy and event counters.
  logic [CW-1:0]   used_total;
  logic [CW-1:0]   used_peak;
  logic [31:0]     loads_done;
  logic [31:0]     unloads_done;
  logic [31:0]     loads_blocked;

  logic [CW-1:0]   used_total_next;
  logic [CW-1:0]   used_peak_next;
  logic [31:0]     loads_done_next;
  logic [31:0]     unloads_done_next;
  logic [31:0]     loads_blocked_next;
  logic [1:0]      status_next;
  logic [OW-1:0]   occ_ext;
  logic [OW-1:0]   peak_ext;
  logic [XW-1:0]   where_ext;
  logic            cur_used;

  // Compare stage: first free slot for a load, first matching used slot
  // for an unload.
  always_comb begin
    cur_used      = slot_used[cmp_idx];
    stat.hit      = cmp_vld && ((cmd_q == spa_pkg::CMD_LOAD) ? !cur_used
                                 : (cur_used && (rd_data == id_q)));
    stat.miss_last = cmp_vld && !stat.hit && (cmp_idx == LAST_IDX);
    stat.out_free = !rsp_valid || !rsp_stall;
  end

  // Next values of the counters at commit.
  always_comb begin
    used_total_next    = used_total;
    used_peak_next     = used_peak;
    loads_done_next    = loads_done;
    unloads_done_next  = unloads_done;
    loads_blocked_next = loads_blocked;
    status_next        = spa_pkg::ST_DONE;
    if (cmd_q == spa_pkg::CMD_LOAD) begin
      if (found_q) begin
        used_total_next = used_total + CW'(1);
        loads_done_next = loads_done + 32'd1;
        if (used_total_next > used_peak) begin
          used_peak_next = used_total_next;
        end
      end else begin
        loads_blocked_next = loads_blocked + 32'd1;
        status_next        = spa_pkg::ST_FULL;
      end
    end else begin
      if (found_q) begin
        if (used_total != '0) begin
          used_total_next = used_total - CW'(1);
        end
        unloads_done_next = unloads_done + 32'd1;
      end else begin
        status_next = spa_pkg::ST_NOMATCH;
      end
    end
    occ_ext   = OW'(used_total_next);
    peak_ext  = OW'(used_peak_next);
    where_ext = found_q ? XW'(where_q) : '0;
  end

  // Request latch, scan pipeline and identifier memory.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_q <= req.command;
      id_q  <= req.owner_id;
      idx   <= '0;
    end else if (cmd.scan && (idx != LAST_IDX)) begin
      idx <= idx + IW'(1);
    end
    cmp_idx <= idx;
    rd_data <= ids_mem[idx];
    if (cmd.capture) begin
      found_q <= stat.hit;
      where_q <= cmp_idx;
    end
    if (cmd.commit && found_q && (cmd_q == spa_pkg::CMD_LOAD)) begin
      ids_mem[where_q] <= id_q;
    end
  end

  // Control state: compare-stage valid, in-use bits, counters, response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld       <= 1'b0;
      slot_used     <= '0;
      used_total    <= '0;
      used_peak     <= '0;
      loads_done    <= '0;
      unloads_done  <= '0;
      loads_blocked <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cmd.start) begin
        cmp_vld <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld <= 1'b1;
      end
      if (cmd.commit) begin
        if (found_q) begin
          slot_used[where_q] <= (cmd_q == spa_pkg::CMD_LOAD);
        end
        used_total    <= used_total_next;
        used_peak     <= used_peak_next;
        loads_done    <= loads_done_next;
        unloads_done  <= unloads_done_next;
        loads_blocked <= loads_blocked_next;
        rsp_valid     <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload, loaded at commit.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.status         <= status_next;
      rsp.slot_index     <= where_ext[2:0];
      rsp.occupancy      <= occ_ext[3:0];
      rsp.peak_occupancy <= peak_ext[3:0];
      rsp.load_count     <= loads_done_next;
      rsp.unload_count   <= unloads_done_next;
      rsp.blocked_count  <= loads_blocked_next;
    end
  end

endmodule

// ===== rtl/spa_controller.sv =====
// Controller of the slot pool allocator: sequences accept, scan and commit.
// Depends on spa_pkg; drives spa_datapath through spa_pkg::dp_cmd_t.
module spa_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  spa_pkg::dp_stat_t stat,
  output spa_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state;
  logic   accept;

  assign accept = req_valid && !req_stall;

  // Commands decoded from the current state, the accept and the datapath status.
  always_comb begin
    cmd.start   = accept;
    cmd.scan    = (state == S_SCAN);
    cmd.capture = (state == S_SCAN) && (stat.hit || stat.miss_last);
    cmd.commit  = (state == S_COMMIT) && stat.out_free;
  end

  // State register and the registered stall output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_stall <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state     <= S_SCAN;
            req_stall <= 1'b1;
          end
        end
        S_SCAN: begin
          if (cmd.capture) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (cmd.commit) begin
            state     <= S_IDLE;
            req_stall <= 1'b0;
          end
        end
        default: begin
          state     <= S_IDLE;
          req_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule
